### src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with asynchronous reset disable (disable iff)
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// same without reset disable
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### src/sha_pkg.sv
// package for the sha-256 engine: item types, round constants, helper functions
// no dependencies
`default_nettype none
package sha_pkg;
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic       write_byte;   // store byte at write pointer
      logic [5:0] byte_addr;
      logic [7:0] byte_value;
      logic       load_sched;   // start compression: load w and working vars
      logic       round;        // run one round
      logic       fold;         // add working vars into hash
      logic       init_hash;    // back to initial values
      logic       shift_hash;   // rotate hash words for output
   } dp_cmd_type;

   typedef struct packed {
      logic [31:0] head_word;
   } dp_stat_type;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

### src/sha256_hash_engine.sv
// sha-256 engine top level: controller plus datapath
// Usage:
//   req channel: one item per message byte (kind 0) or a finish item (kind 1).
//   rsp channel: eight items per finish, digest words 0..7, last_word on word 7.
//   A data item is written into the buffer; the 64th byte of a block starts a
//   compression (load, 64 rounds at one per cycle, fold), during which
//   req_stall is high. A finish item zero-fills the buffer and writes the
//   message length (one byte a cycle), compresses one or two blocks, then
//   presents the digest one word at a time. After the last word the ST_INIT
//   state returns the hash to its initial value and the next message can start.
//   rsp_stall holds the current word in place; no input is taken meanwhile.
//   Reset (synchronous, active high) clears control state and loads the
//   initial hash; the buffer is not cleared.
`default_nettype none
module sha256_hash_engine
   import sha_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [5:0]  round_idx;

   sha_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data, .cmd, .round_idx, .stat
   );

   sha_datapath u_dp (
      .clock, .reset, .cmd, .round_idx, .stat
   );
endmodule
`default_nettype wire

### src/sha_datapath.sv
// sha-256 datapath: block buffer, message schedule, round logic, hash words
// depends on sha_pkg
`default_nettype none
module sha_datapath
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_cmd_type  cmd,
   input  wire logic [5:0]  round_idx,
   output dp_stat_type      stat
);
   logic [31:0] blk_ff [16];
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] hash_ff [8];

   logic [31:0] e, a, big1, big0, choose, major, t1, t2, s0, s1, w_new, w_cur;

   always_comb begin
      w_cur  = w_ff[0];
      s0     = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1     = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new  = s1 + w_ff[9] + s0 + w_ff[0];
      e      = v_ff[4];
      a      = v_ff[0];
      big1   = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
      choose = (e & v_ff[5]) ^ (~e & v_ff[6]);
      t1     = v_ff[7] + big1 + choose + ROUND_K[round_idx] + w_cur;
      big0   = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
      major  = (a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + major;
   end

   // block held as sixteen words, byte 0 in the top lane of word 0
   always_ff @(posedge clock) begin
      if (cmd.write_byte) begin
         blk_ff[cmd.byte_addr[5:2]][8*(3 - cmd.byte_addr[1:0]) +: 8] <= cmd.byte_value;
      end
   end

   // sliding 16-word schedule window
   always_ff @(posedge clock) begin
      if (cmd.load_sched) begin
         for (int i = 0; i < 16; i++) begin
            w_ff[i] <= blk_ff[i];
         end
      end else if (cmd.round) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sched) begin
         v_ff <= hash_ff;
      end else if (cmd.round) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init_hash) begin
         hash_ff <= INIT_HASH;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= hash_ff[i] + v_ff[i];
         end
      end else if (cmd.shift_hash) begin
         for (int i = 0; i < 7; i++) begin
            hash_ff[i] <= hash_ff[i+1];
         end
         hash_ff[7] <= hash_ff[0];
      end
   end

   assign stat.head_word = hash_ff[0];
endmodule
`default_nettype wire

### src/sha_ctrl.sv
// sha-256 controller: byte intake, padding, round sequencing, digest output
// depends on sha_pkg
`default_nettype none
module sha_ctrl
   import sha_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   output dp_cmd_type       cmd,
   output logic [5:0]       round_idx,
   input  wire dp_stat_type stat
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_ROUND = 7'b0001000,
      ST_FOLD  = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_INIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [6:0]  pad_ff, pad_in;        // padding write pointer, bit 6 marks end of block
   logic [5:0]  rnd_ff, rnd_in;
   logic [63:0] bits_ff, bits_in;
   logic [63:0] total_ff, total_in;
   logic        fin_ff, fin_in;        // finishing a message
   logic        last_ff, last_in;      // this compression is the length block
   logic [2:0]  widx_ff, widx_in;
   logic        accept, out_take;
   logic [5:0]  pp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_take  = rsp_valid && !rsp_stall;
   assign round_idx = rnd_ff;
   assign pp        = pad_ff[5:0];

   always_comb begin
      rsp_valid            = (state_ff == ST_OUT);
      rsp_data.digest_word = stat.head_word;
      rsp_data.word_index  = widx_ff;
      rsp_data.last_word   = (widx_ff == 3'd7);
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      pad_in   = pad_ff;
      rnd_in   = rnd_ff;
      bits_in  = bits_ff;
      total_in = total_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      widx_in  = widx_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_DATA) begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr  = fill_ff;
               cmd.byte_value = req_data.data_byte;
               fill_in        = fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  bits_in  = bits_ff + 64'd512;
                  fin_in   = 1'b0;
                  state_in = ST_LOAD;
               end
            end else if (accept) begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr  = fill_ff;
               cmd.byte_value = PAD_BYTE;
               total_in = bits_ff + {55'd0, fill_ff, 3'd0};
               pad_in   = {1'b0, fill_ff} + 7'd1;
               fin_in   = 1'b1;
               last_in  = 1'b0;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // zero fill, then length bytes when this is the final block
            if (pad_ff[6]) begin
               pad_in   = 7'd0;
               state_in = ST_LOAD;
            end else if (!last_ff && pp == LEN_POS && pad_ff <= 7'd56) begin
               last_in = 1'b1;
            end else begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr  = pp;
               cmd.byte_value = 8'd0;
               if (last_ff && pp >= LEN_POS) begin
                  cmd.byte_value = total_ff[63 - 8*(pp - LEN_POS) -: 8];
               end
               pad_in = pad_ff + 7'd1;
            end
         end
         ST_LOAD: begin
            cmd.load_sched = 1'b1;
            rnd_in   = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            rnd_in    = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (last_ff) begin
               widx_in  = 3'd0;
               state_in = ST_OUT;
            end else begin
               // overflow block done, build the length block
               last_in  = 1'b1;
               pad_in   = 7'd0;
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (out_take) begin
               cmd.shift_hash = 1'b1;
               widx_in        = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init_hash = 1'b1;
            fill_in  = 6'd0;
            bits_in  = 64'd0;
            fin_in   = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         widx_ff  <= '0;
         pad_ff   <= '0;
         rnd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         widx_ff  <= widx_in;
         pad_ff   <= pad_in;
         rnd_ff   <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end
endmodule
`default_nettype wire

### src/sha_checker.sv
// port-level checker for the sha-256 engine, bound to the top level
// depends on sha_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sha_checker
   import sha_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   `ASSERT_CLK(a_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "rsp held")
   `ASSERT_CLK(a_last, clock, reset,
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)), "last flag")
   `ASSERT_CLK(a_noin, clock, reset, rsp_valid |-> req_stall, "input during output")
   `ASSERT_CLK(a_seq, clock, reset,
      rsp_valid && !rsp_stall && !rsp_data.last_word |=>
         rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1,
      "word order")
   `ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_valid, "valid after reset")
endmodule

bind sha256_hash_engine sha_checker u_chk (.*);
`default_nettype wire

### tb/sv/tb_sha256_hash_engine.sv
// testbench for sha256_hash_engine: byte and finish items against an in-bench sha-256 predictor
// depends on sha_pkg (item types, kind codes, hash and round constants, pad byte) and the engine rtl
`timescale 1ns / 1ps
`default_nettype none
module tb_sha256_hash_engine
   import sha_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic       kind;
      logic [7:0] data_byte;
      logic       typed;       // expected digest typed in the row
      logic [31:0] known_w0;   // expected first digest word when typed
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sha256_hash_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [31:0] hash_now [8];
   logic [7:0]  msg_block [64];
   int unsigned fill_now;
   logic [63:0] bits_done;
   rsp_type     digest_queue [$];

   int errors = 0;
   int digests_seen = 0;
   int items_sent = 0;
   int idle_mode = 0;         // 0 sender rare idle, 1 receiver rare idle, 2 none
   int hold_off = 0;          // long receiver stall request in cycles
   int watchdog = 0;

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
              + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      v = hash_now;
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_now[i] += v[i];
   endtask

   task automatic restart_hash();
      hash_now = INIT_HASH;
      fill_now = 0;
      bits_done = '0;
   endtask

   task automatic predict_item(input req_type it);
      logic [63:0] total;
      int unsigned pos;
      rsp_type r;
      if (it.kind == KIND_DATA) begin
         msg_block[fill_now] = it.data_byte;
         fill_now++;
         if (fill_now == 64) begin
            fold_block();
            bits_done += 64'd512;
            fill_now = 0;
         end
      end else begin
         pos = fill_now;
         total = bits_done + 64'(pos) * 8;
         msg_block[pos] = PAD_BYTE;
         pos++;
         if (pos > 56) begin
            while (pos < 64) msg_block[pos++] = 8'h00;
            fold_block();
            pos = 0;
         end
         while (pos < 56) msg_block[pos++] = 8'h00;
         for (int i = 0; i < 8; i++) msg_block[56+i] = total[63-8*i -: 8];
         fold_block();
         for (int i = 0; i < 8; i++) begin
            r.digest_word = hash_now[i];
            r.word_index = 3'(i);
            r.last_word = (i == 7);
            digest_queue.push_back(r);
         end
         restart_hash();
      end
   endtask

   // sender: valid drops only while idling, so each step sees one update
   task automatic send_item(input logic kind, input logic [7:0] b);
      req_type it;
      int pct;
      pct = (idle_mode == 0) ? 9 : ((idle_mode == 1) ? 80 : 0);
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      it.kind = kind;
      it.data_byte = b;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // receiver and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else if (idle_mode == 0) begin
            rsp_stall <= ($urandom_range(99) < 80);
         end else if (idle_mode == 1) begin
            rsp_stall <= ($urandom_range(99) < 9);
         end else begin
            rsp_stall <= 1'b0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               $error("digest word with nothing expected: %h", rsp_data.digest_word);
               errors++;
            end else begin
               if (rsp_data.digest_word !== digest_queue[0].digest_word) begin
                  $error("digest_word expected %h actual %h",
                     digest_queue[0].digest_word, rsp_data.digest_word);
                  errors++;
               end
               if (rsp_data.word_index !== digest_queue[0].word_index) begin
                  $error("word_index expected %0d actual %0d",
                     digest_queue[0].word_index, rsp_data.word_index);
                  errors++;
               end
               if (rsp_data.last_word !== digest_queue[0].last_word) begin
                  $error("last_word expected %0d actual %0d",
                     digest_queue[0].last_word, rsp_data.last_word);
                  errors++;
               end
               if (rsp_data.last_word === 1'b1) digests_seen++;
               void'(digest_queue.pop_front());
            end
         end
      end
   end

   // watchdog on accepted traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         watchdog <= 0;
      else
         watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   row_type plan [$];
   logic [31:0] typed_head;

   task automatic add_row(input logic k, input logic [7:0] b,
                          input logic t = 1'b0, input logic [31:0] w0 = '0);
      row_type r;
      r.kind = k; r.data_byte = b; r.typed = t; r.known_w0 = w0;
      plan.push_back(r);
   endtask

   initial begin
      restart_hash();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, "abc", all-ones and zero bytes, double finish
      add_row(KIND_FINISH, 8'h00, 1'b1, 32'he3b0c442);
      add_row(KIND_DATA, 8'h61);
      add_row(KIND_DATA, 8'h62);
      add_row(KIND_DATA, 8'h63);
      add_row(KIND_FINISH, 8'hff, 1'b1, 32'hba7816bf);
      add_row(KIND_DATA, 8'hff);
      add_row(KIND_DATA, 8'h00);
      add_row(KIND_DATA, 8'h55);
      add_row(KIND_DATA, 8'haa);
      add_row(KIND_FINISH, 8'h5a);
      add_row(KIND_FINISH, 8'h00, 1'b1, 32'he3b0c442);
      foreach (plan[i]) begin
         if (plan[i].kind == KIND_FINISH && plan[i].typed) begin
            // the empty and "abc" digests are known constants
            send_item(plan[i].kind, plan[i].data_byte);
            typed_head = digest_queue[digest_queue.size() - 8].digest_word;
            if (typed_head !== plan[i].known_w0) begin
               $error("digest_word expected %h actual %h", plan[i].known_w0, typed_head);
               errors++;
            end
         end else begin
            send_item(plan[i].kind, plan[i].data_byte);
         end
      end
      wait_drained();

      // 120 random bytes: one block compressed on data, then 56 bytes left so
      // the padding spills into an extra block; receiver stalls often first, then sender idles often
      for (int b = 0; b < 120; b++) begin
         if (b == 60) idle_mode = 1;
         send_item(KIND_DATA, 8'($urandom));
      end
      send_item(KIND_FINISH, 8'($urandom));
      wait_drained();

      // long receiver hold while a second finish waits at the input
      idle_mode = 2;
      hold_off = 400;
      send_item(KIND_FINISH, 8'($urandom));
      send_item(KIND_FINISH, 8'($urandom));
      wait_drained();

      repeat (50) @(posedge clock);
      $display("sent %0d items over %0d digests, padding edges and stalls on both sides",
         items_sent, digests_seen);
      if (errors == 0 && digest_queue.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
